/* hdl/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants for the byte stack
// Command codes, cell control struct, controller states and defaults.
// ----------------------------------------------------------------------------
package bsd_pkg;

    // Default number of cells in the chain
    localparam int DEPTH_DEFAULT = 64;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 3;
    localparam int CAP_W  = 7;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Command codes carried in the input tuser
    localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TOP       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP_DOWN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP_UP   = 3'd4;

    // Per-cycle move of the whole cell row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_DOWN,   // each cell takes its upper neighbor, cell 0 takes head byte
        CELL_SHIFT_UP      // each cell takes its lower neighbor
    } cell_op_t;

    // Control broadcast to every cell
    typedef struct packed {
        cell_op_t op;
        logic     wrap_en;   // bottom cell takes the wrap byte on a shift up
    } cell_ctrl_t;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage

/* hdl/bsd_cell.sv */
// ----------------------------------------------------------------------------
// bsd_cell: one stack entry
// Holds one byte and moves it toward the top or the base of the row.
// ----------------------------------------------------------------------------
module bsd_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
) (
    input  logic                             clk,
    input  bsd_pkg::cell_ctrl_t              ctrl,
    input  logic [IDX_W-1:0]                 bottom_idx,
    input  logic [bsd_pkg::BYTE_W-1:0]       upper_byte,
    input  logic [bsd_pkg::BYTE_W-1:0]       lower_byte,
    input  logic [bsd_pkg::BYTE_W-1:0]       wrap_byte,
    output logic [bsd_pkg::BYTE_W-1:0]       data
);

    logic [bsd_pkg::BYTE_W-1:0] data_reg;
    logic [bsd_pkg::BYTE_W-1:0] data_next;
    logic                       is_bottom;

    assign is_bottom = (bottom_idx == IDX_W'(INDEX));

    // Select the value this cell holds next
    always_comb
    begin
        case (ctrl.op)
            bsd_pkg::CELL_SHIFT_DOWN: data_next = upper_byte;
            bsd_pkg::CELL_SHIFT_UP:
            begin
                if (ctrl.wrap_en && is_bottom)
                    data_next = wrap_byte;
                else
                    data_next = lower_byte;
            end
            default: data_next = data_reg;
        endcase
    end

    // Hold the byte
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* hdl/bsd_chain.sv */
// ----------------------------------------------------------------------------
// bsd_chain: row of stack cells
// Cell 0 is the top of the stack; the bottom cell value is selected by index.
// ----------------------------------------------------------------------------
module bsd_chain #(
    parameter int DEPTH = bsd_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             clk,
    input  bsd_pkg::cell_ctrl_t              ctrl,
    input  logic [IDX_W-1:0]                 bottom_idx,
    input  logic [bsd_pkg::BYTE_W-1:0]       head_byte,
    output logic [bsd_pkg::BYTE_W-1:0]       top_byte,
    output logic [bsd_pkg::BYTE_W-1:0]       bottom_byte
);

    logic [bsd_pkg::BYTE_W-1:0] cell_data [DEPTH];

    // Build the row; neighbors are wired cell to cell
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [bsd_pkg::BYTE_W-1:0] upper;
        logic [bsd_pkg::BYTE_W-1:0] lower;

        if (i == 0)
        begin : g_first
            assign upper = head_byte;
        end
        else
        begin : g_mid_up
            assign upper = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign lower = cell_data[i];
        end
        else
        begin : g_mid_low
            assign lower = cell_data[i+1];
        end

        bsd_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .bottom_idx (bottom_idx),
            .upper_byte (upper),
            .lower_byte (lower),
            .wrap_byte  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    assign top_byte    = cell_data[0];
    assign bottom_byte = cell_data[bottom_idx];

endmodule

/* hdl/byte_stack_with_dump_unit.sv */
// ----------------------------------------------------------------------------
// byte_stack_with_dump_unit: bounded byte stack with dump
// Push, pop, show top and two dump orders over a row of shifting cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_*      in         tuser[2:0] command, tdata[7:0] push_byte
//  m_*      out        tdata[7:0] out_byte, tlast last
//  cfg_*    in         cfg_data[6:0] capacity
//
//  Push, pop and show top are taken at one item per cycle while idle and the
//  output is free. A dump of n entries holds s_tready low until its last entry
//  is emitted; it rotates the used cells once per result, so the stack is intact afterwards.
//  Output stalls on m_tready hold the output register and block all new
//  items. Reset empties the stack and sets capacity to 64.
// ----------------------------------------------------------------------------
module byte_stack_with_dump_unit #(
    parameter int DEPTH = bsd_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] push_byte
    input  logic [bsd_pkg::CMD_W-1:0]        s_tuser,   // [2:0] command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bsd_pkg::CAP_W-1:0]        cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bsd_pkg::state_t             state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            remain_reg, remain_next;
    logic                        dir_up_reg, dir_up_next;
    logic [bsd_pkg::CAP_W-1:0]   cap_reg;
    logic                        m_valid_reg, m_valid_next;
    logic [7:0]                  m_data_reg, m_data_next;
    logic                        m_last_reg, m_last_next;

    bsd_pkg::cell_ctrl_t         ctrl;
    logic [7:0]                  head_byte;
    logic [7:0]                  top_byte;
    logic [7:0]                  bottom_byte;
    logic [IDX_W-1:0]            bottom_idx;
    logic                        out_free;
    logic                        has_room;
    logic                        not_empty;

    assign bottom_idx = IDX_W'(count_reg - CNT_W'(1));
    assign out_free   = !m_valid_reg || m_tready;
    assign not_empty  = (count_reg != '0);
    assign has_room   = (bsd_pkg::CAP_W'(count_reg) < cap_reg) &&
                        (count_reg < CNT_W'(DEPTH));
    assign s_tready   = (state_reg == bsd_pkg::ST_IDLE) && out_free;
    assign cfg_ready  = 1'b1;

    // Cell row
    bsd_chain #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_chain (
        .clk         (clk),
        .ctrl        (ctrl),
        .bottom_idx  (bottom_idx),
        .head_byte   (head_byte),
        .top_byte    (top_byte),
        .bottom_byte (bottom_byte)
    );

    // Decode commands and sequence dumps
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        dir_up_next  = dir_up_reg;
        ctrl.op      = bsd_pkg::CELL_HOLD;
        ctrl.wrap_en = 1'b0;
        head_byte    = s_tdata;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            bsd_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    case (s_tuser)
                        bsd_pkg::CMD_PUSH:
                        begin
                            if (has_room)
                            begin
                                ctrl.op    = bsd_pkg::CELL_SHIFT_DOWN;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        bsd_pkg::CMD_POP:
                        begin
                            if (not_empty)
                            begin
                                ctrl.op    = bsd_pkg::CELL_SHIFT_UP;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        bsd_pkg::CMD_TOP:
                        begin
                            if (not_empty)
                            begin
                                m_valid_next = 1'b1;
                                m_data_next  = top_byte;
                                m_last_next  = 1'b1;
                            end
                        end
                        bsd_pkg::CMD_DUMP_DOWN,
                        bsd_pkg::CMD_DUMP_UP:
                        begin
                            if (not_empty)
                            begin
                                state_next  = bsd_pkg::ST_DUMP;
                                remain_next = count_reg;
                                dir_up_next = (s_tuser == bsd_pkg::CMD_DUMP_UP);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bsd_pkg::ST_DUMP:
            begin
                // Emit one entry and rotate the used cells by one
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_last_next  = (remain_reg == CNT_W'(1));
                    remain_next  = remain_reg - CNT_W'(1);
                    if (dir_up_reg)
                    begin
                        m_data_next = bottom_byte;
                        ctrl.op     = bsd_pkg::CELL_SHIFT_DOWN;
                        head_byte   = bottom_byte;
                    end
                    else
                    begin
                        m_data_next  = top_byte;
                        ctrl.op      = bsd_pkg::CELL_SHIFT_UP;
                        ctrl.wrap_en = 1'b1;
                    end
                    if (remain_reg == CNT_W'(1))
                        state_next = bsd_pkg::ST_IDLE;
                end
            end
            default: state_next = bsd_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bsd_pkg::ST_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            dir_up_reg  <= 1'b0;
            cap_reg     <= bsd_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            dir_up_reg  <= dir_up_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
